>>> rtl/core/barycentric_coordinates_3d_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the barycentric coordinate block
// Implication checks with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef BARYCENTRIC_COORDINATES_3D_ASSERT_SVH
`define BARYCENTRIC_COORDINATES_3D_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define BCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset too
`define BCC_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/bcc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcc_pkg
// Shared constants and types of the barycentric coordinate pipeline.
// ---------------------------------------------------------------------------
package bcc_pkg;

    localparam int Q_W       = 32;          // result width
    localparam int DIV_STEPS = Q_W - 1;     // quotient bits below the cap bit
    localparam int LATENCY   = 40;          // accepting edge to result accepting edge

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic degen;
        logic neg_u;
        logic neg_v;
    } t_ctl;

endpackage

>>> rtl/core/bcc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcc_front
// Normal, axis choice and projected sub-areas, six register stages.
// ---------------------------------------------------------------------------
module bcc_front #(
    parameter int COORD_BITS = 16,
    parameter int MW         = 2 * (COORD_BITS + 1) + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic signed [COORD_BITS-1:0] i_a [0:2],
    input  logic signed [COORD_BITS-1:0] i_b [0:2],
    input  logic signed [COORD_BITS-1:0] i_c [0:2],
    input  logic signed [COORD_BITS-1:0] i_p [0:2],
    output logic                         o_vld,
    output logic        [MW-1:0]         o_nu,
    output logic        [MW-1:0]         o_nv,
    output logic        [MW-1:0]         o_den,
    output bcc_pkg::t_ctl                o_ctl
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // stage 1: differences
    logic                 r_v1;
    logic signed [DW-1:0] r_e1 [0:2], r_e2 [0:2];
    logic signed [DW-1:0] r_pb [0:2], r_bc [0:2], r_pc [0:2], r_ca [0:2];
    // stage 2: normal products
    logic                 r_v2;
    logic signed [PW-1:0] r_np [0:5];
    logic signed [DW-1:0] r_pb2 [0:2], r_bc2 [0:2], r_pc2 [0:2], r_ca2 [0:2];
    // stage 3: normal
    logic                 r_v3;
    logic signed [MW-1:0] r_m [0:2];
    logic signed [DW-1:0] r_pb3 [0:2], r_bc3 [0:2], r_pc3 [0:2], r_ca3 [0:2];
    // stage 4: axis choice
    logic                 r_v4, r_deg4, r_dneg4;
    logic        [MW-1:0] r_d4;
    logic signed [DW-1:0] r_s [0:7];
    // stage 5: area products
    logic                 r_v5, r_deg5, r_dneg5;
    logic        [MW-1:0] r_d5;
    logic signed [PW-1:0] r_ap [0:3];
    // stage 6: output
    logic                 r_v6;
    logic        [MW-1:0] r_nu6, r_nv6, r_d6;
    bcc_pkg::t_ctl        r_ctl6;

    logic        [MW-1:0] n_abs [0:2];
    logic        [MW-1:0] n_d;
    logic                 n_dneg, n_deg;
    logic        [1:0]    n_i, n_j;
    logic signed [MW-1:0] n_den, n_nu, n_nv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_e1[k] <= DW'(i_b[k]) - DW'(i_a[k]);
            r_e2[k] <= DW'(i_c[k]) - DW'(i_a[k]);
            r_pb[k] <= DW'(i_p[k]) - DW'(i_b[k]);
            r_bc[k] <= DW'(i_b[k]) - DW'(i_c[k]);
            r_pc[k] <= DW'(i_p[k]) - DW'(i_c[k]);
            r_ca[k] <= DW'(i_c[k]) - DW'(i_a[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_np[0] <= PW'(r_e1[1]) * PW'(r_e2[2]);
        r_np[1] <= PW'(r_e1[2]) * PW'(r_e2[1]);
        r_np[2] <= PW'(r_e1[2]) * PW'(r_e2[0]);
        r_np[3] <= PW'(r_e1[0]) * PW'(r_e2[2]);
        r_np[4] <= PW'(r_e1[0]) * PW'(r_e2[1]);
        r_np[5] <= PW'(r_e1[1]) * PW'(r_e2[0]);
        r_pb2 <= r_pb;
        r_bc2 <= r_bc;
        r_pc2 <= r_pc;
        r_ca2 <= r_ca;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_m[k] <= MW'(r_np[2*k]) - MW'(r_np[2*k+1]);
        end
        r_pb3 <= r_pb2;
        r_bc3 <= r_bc2;
        r_pc3 <= r_pc2;
        r_ca3 <= r_ca2;
    end

    // drop the axis of largest |m|, x over y over z on ties
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_abs[k] = r_m[k][MW-1] ? (~r_m[k] + MW'(1)) : r_m[k];
        end
        n_deg = (r_m[0] == '0) && (r_m[1] == '0) && (r_m[2] == '0);
        priority if (n_abs[0] >= n_abs[1] && n_abs[0] >= n_abs[2]) begin
            n_i   = 2'd1;
            n_j   = 2'd2;
            n_den = r_m[0];
        end else if (n_abs[1] >= n_abs[2]) begin
            n_i   = 2'd0;
            n_j   = 2'd2;
            n_den = -r_m[1];
        end else begin
            n_i   = 2'd0;
            n_j   = 2'd1;
            n_den = r_m[2];
        end
        n_dneg = n_den[MW-1];
        n_d    = n_dneg ? (~n_den + MW'(1)) : n_den;
    end

    always_ff @(posedge i_clk) begin
        r_deg4  <= n_deg;
        r_dneg4 <= n_dneg;
        r_d4    <= n_d;
        r_s[0]  <= r_pb3[n_i];
        r_s[1]  <= r_bc3[n_j];
        r_s[2]  <= r_bc3[n_i];
        r_s[3]  <= r_pb3[n_j];
        r_s[4]  <= r_pc3[n_i];
        r_s[5]  <= r_ca3[n_j];
        r_s[6]  <= r_ca3[n_i];
        r_s[7]  <= r_pc3[n_j];
    end

    always_ff @(posedge i_clk) begin
        r_deg5  <= r_deg4;
        r_dneg5 <= r_dneg4;
        r_d5    <= r_d4;
        for (int k = 0; k < 4; k++) begin
            r_ap[k] <= PW'(r_s[2*k]) * PW'(r_s[2*k+1]);
        end
    end

    always_comb begin
        n_nu = MW'(r_ap[0]) - MW'(r_ap[1]);
        n_nv = MW'(r_ap[2]) - MW'(r_ap[3]);
    end

    always_ff @(posedge i_clk) begin
        r_nu6        <= n_nu[MW-1] ? (~n_nu + MW'(1)) : n_nu;
        r_nv6        <= n_nv[MW-1] ? (~n_nv + MW'(1)) : n_nv;
        r_d6         <= r_d5;
        r_ctl6.degen <= r_deg5;
        r_ctl6.neg_u <= n_nu[MW-1] ^ r_dneg5;
        r_ctl6.neg_v <= n_nv[MW-1] ^ r_dneg5;
    end

    assign o_vld = r_v6;
    assign o_nu  = r_nu6;
    assign o_nv  = r_nv6;
    assign o_den = r_d6;
    assign o_ctl = r_ctl6;

endmodule

>>> rtl/core/bcc_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcc_divider
// Pipelined restoring divider: (n << FRAC_BITS) / d for two numerators,
// one quotient bit per stage, capped at 2^31.
// ---------------------------------------------------------------------------
module bcc_divider #(
    parameter int FRAC_BITS = 16,
    parameter int MW        = 35
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [MW-1:0]           i_nu,
    input  logic [MW-1:0]           i_nv,
    input  logic [MW-1:0]           i_den,
    input  bcc_pkg::t_ctl           i_ctl,
    output logic                    o_vld,
    output logic [bcc_pkg::Q_W-1:0] o_qu,
    output logic [bcc_pkg::Q_W-1:0] o_qv,
    output bcc_pkg::t_ctl           o_ctl
);
    localparam int NS = bcc_pkg::DIV_STEPS;
    localparam int NW = MW + bcc_pkg::Q_W;

    logic          r_vld [0:NS];
    logic [MW-1:0] r_d   [0:NS];
    bcc_pkg::t_ctl r_ctl [0:NS];
    logic          r_ovu [0:NS], r_ovv [0:NS];
    logic [MW-1:0] r_ru  [0:NS], r_rv  [0:NS];
    logic [NS-1:0] r_lu  [0:NS], r_lv  [0:NS];
    logic [NS-1:0] r_qu  [0:NS], r_qv  [0:NS];

    logic [NW-1:0] n_wu, n_wv;

    // entry stage: overflow test on the bits at and above the cap bit
    always_comb begin
        n_wu = NW'(i_nu) << FRAC_BITS;
        n_wv = NW'(i_nv) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0]   <= i_den;
        r_ctl[0] <= i_ctl;
        r_ovu[0] <= n_wu[NW-1:NS] >= {1'b0, i_den};
        r_ovv[0] <= n_wv[NW-1:NS] >= {1'b0, i_den};
        r_ru[0]  <= n_wu[NS+MW-1:NS];
        r_rv[0]  <= n_wv[NS+MW-1:NS];
        r_lu[0]  <= n_wu[NS-1:0];
        r_lv[0]  <= n_wv[NS-1:0];
        r_qu[0]  <= '0;
        r_qv[0]  <= '0;
    end

    for (genvar s = 1; s <= NS; s++) begin : g_step
        logic [MW:0] tu, tv, su, sv;
        logic        gu, gv;

        always_comb begin
            tu = {r_ru[s-1], r_lu[s-1][NS-1]};
            tv = {r_rv[s-1], r_lv[s-1][NS-1]};
            su = tu - {1'b0, r_d[s-1]};
            sv = tv - {1'b0, r_d[s-1]};
            gu = tu >= {1'b0, r_d[s-1]};
            gv = tv >= {1'b0, r_d[s-1]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d[s]   <= r_d[s-1];
            r_ctl[s] <= r_ctl[s-1];
            r_ovu[s] <= r_ovu[s-1];
            r_ovv[s] <= r_ovv[s-1];
            r_ru[s]  <= gu ? su[MW-1:0] : tu[MW-1:0];
            r_rv[s]  <= gv ? sv[MW-1:0] : tv[MW-1:0];
            r_lu[s]  <= {r_lu[s-1][NS-2:0], 1'b0};
            r_lv[s]  <= {r_lv[s-1][NS-2:0], 1'b0};
            r_qu[s]  <= {r_qu[s-1][NS-2:0], gu};
            r_qv[s]  <= {r_qv[s-1][NS-2:0], gv};
        end
    end

    assign o_vld = r_vld[NS];
    assign o_ctl = r_ctl[NS];
    assign o_qu  = r_ovu[NS] ? {1'b1, {NS{1'b0}}} : {1'b0, r_qu[NS]};
    assign o_qv  = r_ovv[NS] ? {1'b1, {NS{1'b0}}} : {1'b0, r_qv[NS]};

endmodule

>>> rtl/core/barycentric_coordinates_3d.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// barycentric_coordinates_3d
// Barycentric weights of a point against a 3D triangle by projection onto
// the plane of the two axes that the normal favors least.
// ---------------------------------------------------------------------------
//  channel   signals                         transaction when
//  input     start, busy, i_a_x .. i_p_z     start && !busy at rising edge
//  result    o_done, o_coord_u .. o_degen..  o_done high, one cycle
//
//  One transaction per cycle, fully pipelined; 40 register stages: 6 geometry
//  stages, a divider entry stage plus 31 quotient-bit stages, a sign stage
//  and the w stage. Divider depth (one restoring step per stage) sets the
//  latency. busy is high only while reset is asserted; reset is synchronous
//  and drops every transaction in flight. The receiver cannot stall, so the
//  pipeline never holds.
// ---------------------------------------------------------------------------
module barycentric_coordinates_3d #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_BITS-1:0]   i_a_x,
    input  logic signed [COORD_BITS-1:0]   i_a_y,
    input  logic signed [COORD_BITS-1:0]   i_a_z,
    input  logic signed [COORD_BITS-1:0]   i_b_x,
    input  logic signed [COORD_BITS-1:0]   i_b_y,
    input  logic signed [COORD_BITS-1:0]   i_b_z,
    input  logic signed [COORD_BITS-1:0]   i_c_x,
    input  logic signed [COORD_BITS-1:0]   i_c_y,
    input  logic signed [COORD_BITS-1:0]   i_c_z,
    input  logic signed [COORD_BITS-1:0]   i_p_x,
    input  logic signed [COORD_BITS-1:0]   i_p_y,
    input  logic signed [COORD_BITS-1:0]   i_p_z,
    output logic                           o_done,
    output logic signed [bcc_pkg::Q_W-1:0] o_coord_u,
    output logic signed [bcc_pkg::Q_W-1:0] o_coord_v,
    output logic signed [bcc_pkg::Q_W-1:0] o_coord_w,
    output logic                           o_degenerate
);
    localparam int QW = bcc_pkg::Q_W;
    localparam int MW = 2 * (COORD_BITS + 1) + 1;   // normal / area width
    localparam int WW = QW + 2;                     // w sum before saturation

    logic signed [COORD_BITS-1:0] w_a [0:2], w_b [0:2], w_c [0:2], w_p [0:2];
    logic                         w_fvld, w_dvld;
    logic        [MW-1:0]         w_nu, w_nv, w_den;
    bcc_pkg::t_ctl                w_fctl, w_dctl;
    logic        [QW-1:0]         w_qu, w_qv;

    // sign stage
    logic                 r_vs, r_degs;
    logic signed [QW-1:0] r_us, r_vvs;
    logic signed [QW-1:0] n_us, n_vvs;
    // output stage
    logic                 r_done, r_deg;
    logic signed [QW-1:0] r_u, r_v, r_w;
    logic signed [WW-1:0] n_wsum;
    logic signed [QW-1:0] n_w;

    assign busy = ~i_rst_n;

    assign w_a = '{i_a_x, i_a_y, i_a_z};
    assign w_b = '{i_b_x, i_b_y, i_b_z};
    assign w_c = '{i_c_x, i_c_y, i_c_z};
    assign w_p = '{i_p_x, i_p_y, i_p_z};

    bcc_front #(
        .COORD_BITS (COORD_BITS),
        .MW         (MW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .i_p     (w_p),
        .o_vld   (w_fvld),
        .o_nu    (w_nu),
        .o_nv    (w_nv),
        .o_den   (w_den),
        .o_ctl   (w_fctl)
    );

    bcc_divider #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fvld),
        .i_nu    (w_nu),
        .i_nv    (w_nv),
        .i_den   (w_den),
        .i_ctl   (w_fctl),
        .o_vld   (w_dvld),
        .o_qu    (w_qu),
        .o_qv    (w_qv),
        .o_ctl   (w_dctl)
    );

    // apply sign; a positive quotient at the cap saturates to the max
    always_comb begin
        if (w_dctl.neg_u) begin
            n_us = QW'(0) - w_qu;
        end else begin
            n_us = w_qu[QW-1] ? bcc_pkg::Q_MAX : w_qu;
        end
        if (w_dctl.neg_v) begin
            n_vvs = QW'(0) - w_qv;
        end else begin
            n_vvs = w_qv[QW-1] ? bcc_pkg::Q_MAX : w_qv;
        end
        // degenerate triangles read back as zero weights
        if (w_dctl.degen) begin
            n_us  = '0;
            n_vvs = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else begin
            r_vs <= w_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_degs <= w_dctl.degen;
        r_us   <= n_us;
        r_vvs  <= n_vvs;
    end

    // w = 1.0 - u - v, saturated
    always_comb begin
        n_wsum = (WW'(1) <<< FRAC_BITS) - WW'(r_us) - WW'(r_vvs);
        priority if (n_wsum > WW'(bcc_pkg::Q_MAX)) begin
            n_w = bcc_pkg::Q_MAX;
        end else if (n_wsum < WW'(bcc_pkg::Q_MIN)) begin
            n_w = bcc_pkg::Q_MIN;
        end else begin
            n_w = n_wsum[QW-1:0];
        end
        if (r_degs) begin
            n_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg <= r_degs;
        r_u   <= r_us;
        r_v   <= r_vvs;
        r_w   <= n_w;
    end

    assign o_done       = r_done;
    assign o_degenerate = r_deg;
    assign o_coord_u    = r_u;
    assign o_coord_v    = r_v;
    assign o_coord_w    = r_w;

endmodule

>>> rtl/core/bcc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the barycentric coordinate block.
// ---------------------------------------------------------------------------
`include "barycentric_coordinates_3d_assert.svh"

module bcc_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input logic signed [bcc_pkg::Q_W-1:0] o_coord_u,
    input logic signed [bcc_pkg::Q_W-1:0] o_coord_v,
    input logic signed [bcc_pkg::Q_W-1:0] o_coord_w,
    input logic                           o_degenerate
);
    localparam logic signed [bcc_pkg::Q_W-1:0] ONE =
        bcc_pkg::Q_W'(1) <<< FRAC_BITS;

    // every result traces back to a transaction a fixed latency earlier
    `BCC_ASSERT_IMPL(a_done_has_source, i_clk, i_rst_n, o_done, $past(start && !busy, bcc_pkg::LATENCY))

    // degenerate triangles give zero weights
    `BCC_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, o_done && o_degenerate, o_coord_u == '0 && o_coord_v == '0 && o_coord_w == '0)

    // zero u and v on a proper triangle leave all weight on C
    `BCC_ASSERT_IMPL(a_w_unity, i_clk, i_rst_n, o_done && !o_degenerate && o_coord_u == '0 && o_coord_v == '0, o_coord_w == ONE)

    // reset flushes the result strobe
    `BCC_ASSERT_NEXT(a_reset_flush, i_clk, !i_rst_n, !o_done)

endmodule

bind barycentric_coordinates_3d bcc_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_bcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_coord_u    (o_coord_u),
    .o_coord_v    (o_coord_v),
    .o_coord_w    (o_coord_w),
    .o_degenerate (o_degenerate)
);
